// ===== hw/rtl/mws_pkg.sv =====
// Shared constants and types for the maximum sliding window sum block.
`timescale 1ns / 1ps
package mws_pkg;

    localparam int WINDOW_MAX_DEF = 1024;
    localparam int LEN_W          = 11;
    localparam int LEN_RESET      = 3;
    localparam int SAMPLE_W       = 8;
    localparam int SUM_W          = 18;
    localparam int Q_DEPTH        = 2;

    // One classified sample on its way from the front end to the back end.
    // The old field already holds zero when the window was not yet full.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic signed [SAMPLE_W-1:0] old;
        logic                       win;
        logic                       last;
    } t_item;

endpackage

// ===== hw/rtl/mws_front.sv =====
// Front end: accepts samples, keeps the ring and fill state, and classifies each beat.
`timescale 1ns / 1ps
module mws_front #(
    parameter int WINDOW_MAX = mws_pkg::WINDOW_MAX_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mws_pkg::LEN_W-1:0]           i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [mws_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                i_last,
    output mws_pkg::t_item                      o_item,
    output logic                                o_item_valid,
    input  logic                                i_item_ready
);
    import mws_pkg::*;

    localparam int POS_W = $clog2(WINDOW_MAX);
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int EW    = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    // A length of zero acts as one, and anything above the ring size as the ring size.
    function automatic logic [CNT_W-1:0] eff_len(input logic [LEN_W-1:0] len);
        logic [EW-1:0] w;
        w = EW'(len);
        if (len == '0) begin
            w = EW'(1);
        end else if (w > EW'(WINDOW_MAX)) begin
            w = EW'(WINDOW_MAX);
        end
        return w[CNT_W-1:0];
    endfunction

    logic [CNT_W-1:0]          r_eff;
    logic [POS_W-1:0]          r_pos;
    logic [CNT_W-1:0]          r_fill;
    logic                      r_vld;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic signed [SAMPLE_W-1:0] r_old;
    logic                      r_full;
    logic                      r_win;
    logic                      r_last;
    logic signed [SAMPLE_W-1:0] r_ring [WINDOW_MAX];

    logic                      accept;
    logic [POS_W-1:0]          pos;
    logic [CNT_W-1:0]          pos_inc;
    logic [POS_W-1:0]          n_pos;
    logic                      full;
    logic [CNT_W-1:0]          n_fill;
    logic                      win;

    assign o_ready = !r_vld || i_item_ready;
    assign accept  = i_valid && o_ready;

    always_comb begin
        pos     = (CNT_W'(r_pos) >= r_eff) ? '0 : r_pos;
        pos_inc = CNT_W'(pos) + CNT_W'(1);
        n_pos   = (pos_inc >= r_eff) ? '0 : pos_inc[POS_W-1:0];
        full    = (r_fill >= r_eff);
        n_fill  = full ? r_fill : r_fill + CNT_W'(1);
        win     = (n_fill >= r_eff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff  <= eff_len(LEN_W'(LEN_RESET));
            r_pos  <= '0;
            r_fill <= '0;
            r_vld  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_eff <= eff_len(i_cfg_data);
            end
            if (accept) begin
                r_pos  <= i_last ? '0 : n_pos;
                r_fill <= i_last ? '0 : n_fill;
                r_vld  <= 1'b1;
            end else if (i_item_ready) begin
                r_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sample <= i_sample;
            r_full   <= full;
            r_win    <= win;
            r_last   <= i_last;
        end
    end

    // The slot is read before it is overwritten, so the oldest sample is registered
    // at the same edge that writes its replacement into the ring.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_old       <= r_ring[pos];
            r_ring[pos] <= i_sample;
        end
    end

    always_comb begin
        o_item.sample = r_sample;
        o_item.old    = r_full ? r_old : '0;
        o_item.win    = r_win;
        o_item.last   = r_last;
    end

    assign o_item_valid = r_vld;

endmodule

// ===== hw/rtl/mws_queue.sv =====
// Short queue of classified beats between the front end and the back end.
`timescale 1ns / 1ps
module mws_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mws_pkg::t_item i_item,
    input  logic           i_valid,
    output logic           o_ready,
    output mws_pkg::t_item o_item,
    output logic           o_valid,
    input  logic           i_ready
);
    import mws_pkg::*;

    localparam int QP_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QC_W = $clog2(Q_DEPTH + 1);

    t_item            r_entry [Q_DEPTH];
    logic [QP_W-1:0]  r_wr;
    logic [QP_W-1:0]  r_rd;
    logic [QC_W-1:0]  r_cnt;

    logic             push;
    logic             pop;

    assign o_ready = (r_cnt != QC_W'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_item  = r_entry[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == QP_W'(Q_DEPTH - 1)) ? '0 : r_wr + QP_W'(1);
            end
            if (pop) begin
                r_rd <= (r_rd == QP_W'(Q_DEPTH - 1)) ? '0 : r_rd + QP_W'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + QC_W'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - QC_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_entry[r_wr] <= i_item;
        end
    end

endmodule

// ===== hw/rtl/mws_back.sv =====
// Back end: keeps the running and best window sums and drives the result register.
`timescale 1ns / 1ps
module mws_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  mws_pkg::t_item                   i_item,
    input  logic                             i_item_valid,
    output logic                             o_item_ready,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic signed [mws_pkg::SUM_W-1:0] o_max_sum,
    output logic                             o_no_window
);
    import mws_pkg::*;

    logic signed [SUM_W-1:0] r_sum;
    logic signed [SUM_W-1:0] r_best;
    logic                    r_have;
    logic                    r_ovld;
    logic signed [SUM_W-1:0] r_max_sum;
    logic                    r_no_window;

    logic                    pop;
    logic signed [SUM_W-1:0] n_sum;
    logic signed [SUM_W-1:0] n_best;
    logic                    n_have;

    // A beat is taken only when its result, if any, has somewhere to go.
    assign o_item_ready = !r_ovld || i_ready;
    assign pop          = i_item_valid && o_item_ready;

    always_comb begin
        n_sum  = r_sum + SUM_W'(i_item.sample) - SUM_W'(i_item.old);
        n_best = r_best;
        n_have = r_have;
        if (i_item.win) begin
            if (!r_have || (n_sum > r_best)) begin
                n_best = n_sum;
            end
            n_have = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_best <= '0;
            r_have <= 1'b0;
            r_ovld <= 1'b0;
        end else begin
            if (pop) begin
                if (i_item.last) begin
                    r_sum  <= '0;
                    r_best <= '0;
                    r_have <= 1'b0;
                end else begin
                    r_sum  <= n_sum;
                    r_best <= n_best;
                    r_have <= n_have;
                end
            end
            if (pop && i_item.last) begin
                r_ovld <= 1'b1;
            end else if (i_ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && i_item.last) begin
            r_max_sum   <= n_have ? n_best : '0;
            r_no_window <= !n_have;
        end
    end

    assign o_valid     = r_ovld;
    assign o_max_sum   = r_max_sum;
    assign o_no_window = r_no_window;

endmodule

// ===== hw/rtl/max_window_sum_top.sv =====
// Maximum sliding window sum: one sample beat per cycle, one result beat per sequence.
// The last sample passes the front register, a queue entry and the result register
// before o_valid rises. Throughput: one sample per cycle while nothing stalls; the
// result register and a two-entry queue absorb stalls.
// Reset is synchronous, active low; it clears running and best sums, counts, handshakes and
// sets the length to three; the ring is not cleared, so a grown window can read stale slots.
`timescale 1ns / 1ps
module max_window_sum_top #(
    parameter int WINDOW_MAX = mws_pkg::WINDOW_MAX_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mws_pkg::LEN_W-1:0]           i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [mws_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                i_last,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [mws_pkg::SUM_W-1:0]    o_max_sum,
    output logic                                o_no_window
);
    import mws_pkg::*;

    t_item fq_item;
    logic  fq_valid;
    logic  fq_ready;
    t_item qb_item;
    logic  qb_valid;
    logic  qb_ready;

    mws_front #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_sample     (i_sample),
        .i_last       (i_last),
        .o_item       (fq_item),
        .o_item_valid (fq_valid),
        .i_item_ready (fq_ready)
    );

    mws_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (fq_item),
        .i_valid (fq_valid),
        .o_ready (fq_ready),
        .o_item  (qb_item),
        .o_valid (qb_valid),
        .i_ready (qb_ready)
    );

    mws_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (qb_item),
        .i_item_valid (qb_valid),
        .o_item_ready (qb_ready),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_max_sum    (o_max_sum),
        .o_no_window  (o_no_window)
    );

endmodule

// ===== hw/rtl/mws_checker.sv =====
// Port-level checks for the maximum sliding window sum block, bound to the top level.
`timescale 1ns / 1ps
module mws_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_cfg_we,
    input logic [mws_pkg::LEN_W-1:0]           i_cfg_data,
    input logic                                i_valid,
    input logic                                o_ready,
    input logic signed [mws_pkg::SAMPLE_W-1:0] i_sample,
    input logic                                i_last,
    input logic                                o_valid,
    input logic                                i_ready,
    input logic signed [mws_pkg::SUM_W-1:0]    o_max_sum,
    input logic                                o_no_window
);

    // A result beat that is not taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result beat dropped while stalled");

    // A short sequence reports a zero sum alongside the flag.
    a_no_window_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_no_window |-> o_max_sum == '0)
        else $error("no_window result carries a nonzero sum");

    // Reset leaves no result pending.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // No new result may appear too soon after reset: the property requires reset to have
    // been released in every earlier cycle that it samples.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid ##1 o_valid |-> $past(i_rst_n, 3) && $past(i_rst_n, 2) && $past(i_rst_n, 1))
        else $error("result appeared too soon after reset");

endmodule

bind max_window_sum_top mws_checker u_mws_checker (.*);

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the maximum sliding window sum block.
`timescale 1ns / 1ps
module tb_top;
    import mws_pkg::*;

    localparam int RING_DEPTH   = WINDOW_MAX_DEF;
    localparam int SETTLE       = 6;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 5000;
    localparam int RANDOM_ITEMS = 230;

    typedef struct {
        logic signed [SUM_W-1:0] max_sum;
        logic                    no_window;
    } t_window_result;

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_cfg_we    = 1'b0;
    logic [LEN_W-1:0]           i_cfg_data  = '0;
    logic                       i_valid     = 1'b0;
    logic                       o_ready;
    logic signed [SAMPLE_W-1:0] i_sample    = '0;
    logic                       i_last      = 1'b0;
    logic                       o_valid;
    logic                       i_ready     = 1'b0;
    logic signed [SUM_W-1:0]    o_max_sum;
    logic                       o_no_window;

    // Independent copy of the block state, advanced on every accepted sample beat.
    logic signed [SAMPLE_W-1:0] ring_mem [0:RING_DEPTH-1];
    int unsigned                ring_at;
    int unsigned                held;
    logic signed [SUM_W-1:0]    win_total;
    logic signed [SUM_W-1:0]    top_total;
    bit                         seen_full;
    logic [LEN_W-1:0]           win_len;

    t_window_result best_sum_q[$];

    int  src_idle_pct  = 13;
    int  sink_idle_pct = 63;
    int  n_errors      = 0;
    int  n_samples     = 0;
    int  n_sequences   = 0;
    int  n_results     = 0;
    int  n_len_writes  = 0;
    int  quiet_cycles  = 0;
    int  hold_left     = 0;
    logic hold_kick    = 1'b0;
    logic hold_seen    = 1'b0;

    max_window_sum_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_sample    (i_sample),
        .i_last      (i_last),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_max_sum   (o_max_sum),
        .o_no_window (o_no_window)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned span_of(input logic [LEN_W-1:0] len);
        if (len == 0) begin
            return 1;
        end
        if (len > RING_DEPTH) begin
            return RING_DEPTH;
        end
        return 32'(len);
    endfunction

    function automatic void clear_window_state();
        ring_at   = 0;
        held      = 0;
        win_total = '0;
        top_total = '0;
        seen_full = 1'b0;
    endfunction

    // Running-sum update for one sample; a last beat queues the best window sum.
    function automatic void advance_window(input logic signed [SAMPLE_W-1:0] s, input logic l);
        int unsigned    span;
        t_window_result r;
        span = span_of(win_len);
        if (ring_at >= span) begin
            ring_at = 0;
        end
        if (held < span) begin
            win_total = win_total + s;
            held++;
        end else begin
            win_total = win_total + s - ring_mem[ring_at];
        end
        ring_mem[ring_at] = s;
        ring_at++;
        if (ring_at >= span) begin
            ring_at = 0;
        end
        if (held >= span) begin
            if (!seen_full || win_total > top_total) begin
                top_total = win_total;
            end
            seen_full = 1'b1;
        end
        if (l) begin
            r.max_sum   = seen_full ? top_total : '0;
            r.no_window = !seen_full;
            best_sum_q.push_back(r);
            n_sequences++;
            clear_window_state();
        end
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample(input bit wide);
        if (wide) begin
            return SAMPLE_W'($urandom_range(255));
        end
        return SAMPLE_W'(int'($urandom_range(200)) - 100);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        n_errors++;
    endtask

    // Offers one sample beat, with an occasional random gap first, and waits for acceptance.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic l);
        if ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        i_valid  <= 1'b1;
        i_sample <= s;
        i_last   <= l;
        do @(posedge i_clk); while (!o_ready);
        n_samples++;
        advance_window(s, l);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (best_sum_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_window_len(input logic [LEN_W-1:0] v);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        win_len = v;
        n_len_writes++;
    endtask

    task automatic test_default_window();
        send_sample(8'sd100, 1'b0);
        send_sample(8'sd100, 1'b0);
        send_sample(8'sd100, 1'b0);
        send_sample(-8'sd100, 1'b0);
        send_sample(8'sd50, 1'b1);
    endtask

    task automatic test_short_sequences();
        send_sample(8'sd7, 1'b1);
        send_sample(-8'sd3, 1'b0);
        send_sample(8'sd9, 1'b1);
    endtask

    task automatic test_extreme_samples();
        write_window_len(11'd2);
        send_sample(-8'sd128, 1'b0);
        send_sample(-8'sd128, 1'b0);
        send_sample(8'sd127, 1'b0);
        send_sample(8'sd127, 1'b1);
        // All windows negative: the first full window must still set the best sum.
        write_window_len(11'd1);
        send_sample(-8'sd100, 1'b0);
        send_sample(-8'sd128, 1'b0);
        send_sample(-8'sd5, 1'b1);
    endtask

    task automatic test_zero_length();
        write_window_len(11'd0);
        send_sample(8'sd5, 1'b0);
        send_sample(-8'sd3, 1'b0);
        send_sample(8'sd7, 1'b1);
    endtask

    // The largest window, asked for with a length above the ring size; this also
    // writes every ring entry before any length change.
    task automatic test_long_windows();
        write_window_len(11'd2047);
        for (int k = 0; k < RING_DEPTH + 6; k++) begin
            send_sample(k < RING_DEPTH ? -8'sd128 : pick_sample(1'b1), k == RING_DEPTH + 5);
        end
    endtask

    task automatic test_length_change();
        // Shrinking: the ring position restarts and the held count already covers a window.
        write_window_len(11'd5);
        for (int k = 0; k < 4; k++) begin
            send_sample(pick_sample(1'b0), 1'b0);
        end
        write_window_len(11'd3);
        for (int k = 0; k < 4; k++) begin
            send_sample(pick_sample(1'b0), k == 3);
        end
        // Growing: the window fills again across slots left over from earlier sequences.
        write_window_len(11'd2);
        for (int k = 0; k < 3; k++) begin
            send_sample(pick_sample(1'b1), 1'b0);
        end
        write_window_len(11'd6);
        for (int k = 0; k < 8; k++) begin
            send_sample(pick_sample(1'b1), k == 7);
        end
    endtask

    // One-sample sequences pile up results while the receiver holds off.
    task automatic test_backpressure();
        write_window_len(11'd1);
        hold_kick <= ~hold_kick;
        for (int k = 0; k < 24; k++) begin
            send_sample(pick_sample(1'b1), 1'b1);
        end
    endtask

    task automatic test_random_sequences(input int n_items);
        int          sent;
        int          seq_len;
        int          cut;
        int          roll;
        int unsigned span;
        bit          wide;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(3) == 0) begin
                roll = $urandom_range(99);
                if (roll < 5) begin
                    write_window_len(11'd0);
                end else if (roll < 12) begin
                    write_window_len(LEN_W'($urandom_range(64, 13)));
                end else if (roll < 14) begin
                    write_window_len(LEN_W'($urandom_range(2047, 1025)));
                end else begin
                    write_window_len(LEN_W'($urandom_range(12, 1)));
                end
            end
            span = span_of(win_len);
            if (span > 64) begin
                seq_len = $urandom_range(40, 1);
            end else if ($urandom_range(4) == 0) begin
                seq_len = $urandom_range(span, 1);
            end else begin
                seq_len = $urandom_range(3 * span + 4, span);
            end
            cut  = ($urandom_range(9) == 0) ? $urandom_range(seq_len - 1, 0) : -1;
            wide = ($urandom_range(9) == 0);
            for (int k = 0; k < seq_len; k++) begin
                if (k == cut && k != 0) begin
                    write_window_len(LEN_W'($urandom_range(16, 0)));
                end
                send_sample(pick_sample(wide), k == seq_len - 1);
            end
            sent += seq_len;
        end
    endtask

    always @(posedge i_clk) begin
        if (hold_kick != hold_seen) begin
            hold_seen <= hold_kick;
            hold_left <= HOLD_CYCLES;
            i_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else begin
            i_ready   <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_window_result want;
        if (i_rst_n && o_valid && i_ready) begin
            n_results++;
            if (best_sum_q.size() == 0) begin
                report_mismatch($sformatf("result with none expected: max_sum %0d no_window %0b",
                                          o_max_sum, o_no_window));
            end else begin
                want = best_sum_q.pop_front();
                if (o_max_sum !== want.max_sum) begin
                    report_mismatch($sformatf("max_sum got %0d, expected %0d",
                                              o_max_sum, want.max_sum));
                end
                if (o_no_window !== want.no_window) begin
                    report_mismatch($sformatf("no_window got %0b, expected %0b",
                                              o_no_window, want.no_window));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no beat accepted for %0d cycles", STALL_LIMIT);
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        for (int k = 0; k < RING_DEPTH; k++) begin
            ring_mem[k] = '0;
        end
        clear_window_state();
        win_len = LEN_W'(LEN_RESET);
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_window();
        test_short_sequences();
        test_extreme_samples();
        test_zero_length();
        test_long_windows();
        test_length_change();
        test_backpressure();
        test_random_sequences(RANDOM_ITEMS);
        src_idle_pct  = 63;
        sink_idle_pct = 13;
        test_random_sequences(RANDOM_ITEMS);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random_sequences(RANDOM_ITEMS);

        wait_drained();
        repeat (10) @(posedge i_clk);
        $display("Covered %0d samples in %0d sequences over %0d window length writes,",
                 n_samples, n_sequences, n_len_writes);
        $display("with %0d results checked and %0d errors.", n_results, n_errors);
        if (n_errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/mws_pkg.sv
hw/rtl/mws_front.sv
hw/rtl/mws_queue.sv
hw/rtl/mws_back.sv
hw/rtl/max_window_sum_top.sv
hw/rtl/mws_checker.sv
tb/sv/tb_top.sv
